### design/temt_pkg.sv
// shared types, constants and helpers for the tunnel endpoint match table
`timescale 1ns / 1ps
package temt_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int RANK_W  = $clog2(ENTRIES);

  localparam logic [2:0] OP_LOOKUP = 3'd0;
  localparam logic [2:0] OP_FIND   = 3'd1;
  localparam logic [2:0] OP_CREATE = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_SET_UP = 3'd4;

  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_CREATED   = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_BAD_INDEX = 3'd4;

  localparam logic [1:0] CLS_BOTH   = 2'd0;
  localparam logic [1:0] CLS_REMOTE = 2'd1;
  localparam logic [1:0] CLS_LOCAL  = 2'd2;
  localparam logic [1:0] CLS_WILD   = 2'd3;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] remote_addr;
    logic [31:0] local_addr;
    logic [3:0]  entry_index;
    logic        up_value;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] result_index;
    logic [1:0] match_class;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic             load;
    logic             rd;
    logic [IDX_W-1:0] rd_addr;
    logic             finish;
  } ctl_t;

  function automatic logic [1:0] class_of(logic [31:0] rem, logic [31:0] loc);
    logic r;
    logic l;
    r = (rem != 32'd0);
    l = (loc != 32'd0);
    if (r && l) return CLS_BOTH;
    if (r) return CLS_REMOTE;
    if (l) return CLS_LOCAL;
    return CLS_WILD;
  endfunction

endpackage

### design/temt_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module temt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/temt_ctrl.sv
// controller: sequences the entry scan and the finishing cycle
`timescale 1ns / 1ps
module temt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [2:0]    op,
  output logic          busy,
  output temt_pkg::ctl_t ctl
);
  import temt_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_WAIT   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  logic [1:0]       state, state_next;
  logic [IDX_W-1:0] cnt, cnt_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          cnt_next = '0;
          if (op inside {OP_LOOKUP, OP_FIND, OP_CREATE}) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        ctl.rd      = 1'b1;
        ctl.rd_addr = cnt;
        cnt_next    = cnt + IDX_W'(1);
        if (cnt == LAST) begin
          state_next = S_WAIT;
        end
      end
      // last read word is compared here
      S_WAIT: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        ctl.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign busy = (state != S_IDLE);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted word did not raise busy");
  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_FINISH |=> state == S_IDLE) else $error("finish not followed by idle");
  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    ctl.rd && cnt == LAST |=> state == S_WAIT) else $error("scan overran the table");
  a_finish_once: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |=> !ctl.finish) else $error("finish held for two cycles");

endmodule

### design/temt_dpath.sv
// datapath: entry storage, scan trackers, result and table updates
`timescale 1ns / 1ps
module temt_dpath (
  input  logic           clk,
  input  logic           rst,
  input  temt_pkg::req_t request,
  input  temt_pkg::ctl_t ctl,
  output logic           done,
  output temt_pkg::rsp_t result
);
  import temt_pkg::*;

  req_t              req_q;
  logic [ENTRIES-1:0] valid;
  logic [ENTRIES-1:0] up;
  logic [RANK_W-1:0] rank [ENTRIES];

  logic [63:0]      rd_data;
  logic             scan_vld;
  logic [IDX_W-1:0] scan_idx;

  // per-class best candidate so far
  logic [3:0]        cls_hit;
  logic [IDX_W-1:0]  cls_idx  [4];
  logic [RANK_W-1:0] cls_rank [4];
  logic              wild_up;

  logic              ex_hit;
  logic [IDX_W-1:0]  ex_idx;
  logic [RANK_W-1:0] ex_rank;

  logic              free_hit;
  logic [IDX_W-1:0]  free_idx;

  logic [31:0]       e_rem, e_loc;
  logic [1:0]        e_cls;
  logic              e_v, e_u, e_match, e_cand;
  logic [RANK_W-1:0] e_r;

  logic [IDX_W-1:0]  ent_idx;
  logic              idx_ok;
  logic [RANK_W-1:0] gone;
  logic              do_create, do_remove, do_setup;
  rsp_t              res_next;

  temt_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_addr_ram (
    .clk   (clk),
    .we    (ctl.finish && do_create),
    .waddr (free_idx),
    .wdata ({req_q.remote_addr, req_q.local_addr}),
    .raddr (ctl.rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    e_rem = rd_data[63:32];
    e_loc = rd_data[31:0];
    e_cls = class_of(e_rem, e_loc);
    e_v   = valid[scan_idx];
    e_u   = up[scan_idx];
    e_r   = rank[scan_idx];
    case (e_cls)
      CLS_BOTH:   e_match = (e_rem == req_q.remote_addr) && (e_loc == req_q.local_addr);
      CLS_REMOTE: e_match = (e_rem == req_q.remote_addr);
      CLS_LOCAL:  e_match = (e_loc == req_q.local_addr);
      default:    e_match = 1'b1;
    endcase
    // the wildcard class takes its newest entry up or not
    e_cand = scan_vld && e_v && e_match && ((e_cls == CLS_WILD) || e_u);
  end

  always_comb begin
    ent_idx   = IDX_W'(req_q.entry_index);
    idx_ok    = (32'(req_q.entry_index) < 32'(ENTRIES)) && valid[ent_idx];
    gone      = rank[ent_idx];
    do_create = (req_q.op == OP_CREATE) && !ex_hit && free_hit;
    do_remove = (req_q.op == OP_REMOVE) && idx_ok;
    do_setup  = (req_q.op == OP_SET_UP) && idx_ok;

    res_next.status       = ST_NOT_FOUND;
    res_next.result_index = 4'd0;
    res_next.match_class  = CLS_BOTH;
    case (req_q.op)
      OP_LOOKUP: begin
        if (cls_hit[0]) begin
          res_next.status       = ST_FOUND;
          res_next.result_index = 4'(cls_idx[0]);
          res_next.match_class  = CLS_BOTH;
        end else if (cls_hit[1]) begin
          res_next.status       = ST_FOUND;
          res_next.result_index = 4'(cls_idx[1]);
          res_next.match_class  = CLS_REMOTE;
        end else if (cls_hit[2]) begin
          res_next.status       = ST_FOUND;
          res_next.result_index = 4'(cls_idx[2]);
          res_next.match_class  = CLS_LOCAL;
        end else if (cls_hit[3] && wild_up) begin
          res_next.status       = ST_FOUND;
          res_next.result_index = 4'(cls_idx[3]);
          res_next.match_class  = CLS_WILD;
        end
      end
      OP_FIND, OP_CREATE: begin
        if (ex_hit) begin
          res_next.status       = ST_FOUND;
          res_next.result_index = 4'(ex_idx);
          res_next.match_class  = class_of(req_q.remote_addr, req_q.local_addr);
        end else if (req_q.op == OP_CREATE) begin
          if (free_hit) begin
            res_next.status       = ST_CREATED;
            res_next.result_index = 4'(free_idx);
            res_next.match_class  = class_of(req_q.remote_addr, req_q.local_addr);
          end else begin
            res_next.status = ST_FULL;
          end
        end
      end
      OP_REMOVE, OP_SET_UP: begin
        res_next.result_index = req_q.entry_index;
        res_next.status       = idx_ok ? ST_FOUND : ST_BAD_INDEX;
      end
      default: begin
        res_next.status = ST_NOT_FOUND;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      up       <= '0;
      done     <= 1'b0;
      scan_vld <= 1'b0;
      cls_hit  <= '0;
      ex_hit   <= 1'b0;
      free_hit <= 1'b0;
    end else begin
      done     <= ctl.finish;
      scan_vld <= ctl.rd;
      if (ctl.load) begin
        cls_hit  <= '0;
        ex_hit   <= 1'b0;
        free_hit <= 1'b0;
      end else if (scan_vld) begin
        if (e_cand && (!cls_hit[e_cls] || e_r < cls_rank[e_cls])) begin
          cls_hit[e_cls] <= 1'b1;
        end
        if (e_v && e_rem == req_q.remote_addr && e_loc == req_q.local_addr &&
            (!ex_hit || e_r < ex_rank)) begin
          ex_hit <= 1'b1;
        end
        if (!e_v) begin
          free_hit <= 1'b1;
        end
      end
      if (ctl.finish) begin
        if (do_create) begin
          valid[free_idx] <= 1'b1;
          up[free_idx]    <= 1'b0;
        end
        if (do_remove) begin
          valid[ent_idx] <= 1'b0;
          up[ent_idx]    <= 1'b0;
        end
        if (do_setup) begin
          up[ent_idx] <= req_q.up_value;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_q <= request;
    end
    scan_idx <= ctl.rd_addr;
    if (scan_vld) begin
      if (e_cand && (!cls_hit[e_cls] || e_r < cls_rank[e_cls])) begin
        cls_idx[e_cls]  <= scan_idx;
        cls_rank[e_cls] <= e_r;
        if (e_cls == CLS_WILD) begin
          wild_up <= e_u;
        end
      end
      if (e_v && e_rem == req_q.remote_addr && e_loc == req_q.local_addr &&
          (!ex_hit || e_r < ex_rank)) begin
        ex_idx  <= scan_idx;
        ex_rank <= e_r;
      end
      if (!e_v && !free_hit) begin
        free_idx <= scan_idx;
      end
    end
    if (ctl.finish) begin
      result <= res_next;
    end
  end

  // recency ranks: 0 is the newest valid entry
  always_ff @(posedge clk) begin
    if (ctl.finish && do_create) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid[i]) begin
          rank[i] <= rank[i] + RANK_W'(1);
        end
      end
      rank[free_idx] <= '0;
    end else if (ctl.finish && do_remove) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid[i] && rank[i] > gone) begin
          rank[i] <= rank[i] - RANK_W'(1);
        end
      end
    end
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");
  a_up_valid: assert property (@(posedge clk) disable iff (rst)
    (up & ~valid) == '0) else $error("up mark on a free entry");
  a_create_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.finish && do_create |=> valid[free_idx]) else $error("created entry not valid");
  a_free_slot: assert property (@(posedge clk) disable iff (rst)
    ctl.finish && do_create |-> !valid[free_idx]) else $error("create into a used slot");

endmodule

### design/tunnel_endpoint_match_table_unit.sv
// IPv4 tunnel endpoint match table: top level
// Usage: drive a request word and raise start; the word is taken at a clock edge
// where start is high and busy is low. Ops are lookup, find exact, find or create,
// remove and set up mark. Each word gives exactly one result word, shown on result
// for one cycle with done high; the receiver must take it then, it cannot stall.
// Lookup, find exact and find or create scan the entry table one entry per cycle
// through the address ram read port; a wait state then compares the last read word,
// a finishing state follows and done is registered from it. Busy drops in the same
// cycle that done is high, so a new word can be taken at its closing edge.
// Remove and set up mark skip the scan: the accept goes straight to the finishing
// state, then done, and other op codes take the same path and answer not found.
// Reset (rst, synchronous, active high) frees every entry and clears all up marks;
// no clearing pass is needed, since entry valid bits live in flip-flops.
`timescale 1ns / 1ps
module tunnel_endpoint_match_table_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  temt_pkg::req_t request,
  output logic           done,
  output temt_pkg::rsp_t result
);
  import temt_pkg::*;

  ctl_t ctl;

  temt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (request.op),
    .busy  (busy),
    .ctl   (ctl)
  );

  temt_dpath u_dpath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .ctl     (ctl),
    .done    (done),
    .result  (result)
  );

endmodule
